/* hw/rtl/i2cmm_pkg.sv */
`default_nettype none
package i2cmm_pkg;

  localparam int unsigned PAGE_BITS = 8;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned TICKS_W = 11;
  localparam logic [TICKS_W-1:0] MAX_PERIOD = 11'd1024;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_BYTE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY = 2'd1;
  localparam logic [1:0] ST_BUS_ERR = 2'd2;
  localparam logic [1:0] ST_NO_ACK = 2'd3;

  localparam logic [1:0] CFG_DEVICE_CODE = 2'd0;
  localparam logic [1:0] CFG_TICKS = 2'd1;

  localparam logic [3:0] DEVICE_CODE_RST = 4'hA;
  localparam logic [TICKS_W-1:0] TICKS_RST = 11'd1;

  typedef struct packed {
    logic [3:0]         device_code;
    logic [TICKS_W-1:0] ticks_per_phase;
  } cfg_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       want_byte;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/i2cmm_seq.sv */
`default_nettype none
module i2cmm_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [1:0]                req_type,
  input  wire logic [10:0]               mem_address,
  input  wire logic [15:0]               byte_count,
  input  wire logic [7:0]                write_data,
  input  wire logic                      sda_in,
  input  wire i2cmm_pkg::cfg_t           cfg,
  output i2cmm_pkg::res_t                res
);
  import i2cmm_pkg::*;

  typedef enum logic [3:0] {
    SEG_IDLE, SEG_START, SEG_DEV, SEG_OFF, SEG_WAIT, SEG_WDATA,
    SEG_RSTART, SEG_RDEV, SEG_RECV, SEG_RACK, SEG_STOP
  } seg_t;

  typedef struct packed {
    seg_t        seg;
    logic [1:0]  micro;
    logic [9:0]  timer;
    logic [3:0]  bitcnt;
    logic [7:0]  shift;
    logic [15:0] left;
    logic        is_read;
    logic [7:0]  dev;
    logic [7:0]  offs;
    logic        scl;
    logic        sda;
    logic [1:0]  status;
  } st_t;

  st_t st_r;
  st_t st_nxt;

  function automatic st_t enter(st_t s, seg_t seg, logic [1:0] m);
    st_t r;
    r = s;
    r.seg = seg;
    r.micro = m;
    r.timer = '0;
    case (seg)
      SEG_START: begin
        if (m == 2'd0) begin
          r.scl = 1'b1;
          r.sda = 1'b1;
        end else if (m == 2'd1) begin
          r.sda = 1'b0;
        end
      end
      SEG_RSTART: begin
        if (m == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else if (m == 2'd1) begin
          r.scl = 1'b1;
        end else if (m == 2'd2) begin
          r.sda = 1'b0;
        end
      end
      SEG_DEV, SEG_OFF, SEG_WDATA, SEG_RDEV: begin
        if (m == 2'd0) begin
          r.scl = 1'b0;
        end else if (m == 2'd1) begin
          if (s.bitcnt < 4'd8) begin
            r.sda = s.shift[7];
            r.shift = {s.shift[6:0], 1'b0};
          end else begin
            r.sda = 1'b1;
          end
        end else begin
          r.scl = 1'b1;
        end
      end
      SEG_WAIT: r.scl = 1'b0;
      SEG_RECV: begin
        if (m == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else begin
          r.scl = 1'b1;
        end
      end
      SEG_RACK: begin
        if (m == 2'd0 || m == 2'd3) begin
          r.scl = 1'b0;
        end else if (m == 2'd1) begin
          r.sda = (s.left == 16'd1);
        end else begin
          r.scl = 1'b1;
        end
      end
      SEG_STOP: begin
        if (m == 2'd0) begin
          r.scl = 1'b0;
        end else if (m == 2'd1) begin
          r.sda = 1'b0;
        end else if (m == 2'd2) begin
          r.scl = 1'b1;
        end else begin
          r.sda = 1'b1;
        end
      end
      default: begin
        r.seg = SEG_IDLE;
        r.scl = 1'b1;
        r.sda = 1'b1;
      end
    endcase
    return r;
  endfunction

  logic [TICKS_W-1:0] period;
  logic [TICKS_W-1:0] timer_inc;
  logic [1:0]         micro_inc;
  logic [15:0]        left_dec;
  logic [7:0]         recv_byte;
  logic [3:0]         bit_inc;
  logic               ev_valid;
  logic               ev_last;
  logic               ev_done;
  logic [7:0]         ev_data;

  always_comb begin
    if (cfg.ticks_per_phase == '0) begin
      period = TICKS_W'(1);
    end else if (cfg.ticks_per_phase > MAX_PERIOD) begin
      period = MAX_PERIOD;
    end else begin
      period = cfg.ticks_per_phase;
    end
    timer_inc = {1'b0, st_r.timer} + TICKS_W'(1);
    micro_inc = st_r.micro + 2'd1;
    left_dec = st_r.left - 16'd1;
    recv_byte = {st_r.shift[6:0], sda_in};
    bit_inc = st_r.bitcnt + 4'd1;
  end

  always_comb begin
    st_nxt = st_r;
    ev_valid = 1'b0;
    ev_last = 1'b0;
    ev_done = 1'b0;
    ev_data = '0;
    if (accept) begin
      case (req_type)
        REQ_TICK: begin
          if (st_r.seg != SEG_IDLE && st_r.seg != SEG_WAIT) begin
            if (timer_inc < period) begin
              st_nxt.timer = timer_inc[9:0];
            end else begin
              st_nxt.timer = '0;
              case (st_r.seg)
                SEG_START: begin
                  if (st_r.micro == 2'd0 && !sda_in) begin
                    st_nxt.status = ST_BUS_BUSY;
                    ev_done = 1'b1;
                    st_nxt.bitcnt = '0;
                    st_nxt = enter(st_nxt, SEG_IDLE, 2'd0);
                  end else if (st_r.micro == 2'd1 && sda_in) begin
                    st_nxt.status = ST_BUS_ERR;
                    ev_done = 1'b1;
                    st_nxt.bitcnt = '0;
                    st_nxt = enter(st_nxt, SEG_IDLE, 2'd0);
                  end else if (st_r.micro < 2'd2) begin
                    st_nxt = enter(st_nxt, SEG_START, micro_inc);
                  end else begin
                    st_nxt.shift = st_r.dev;
                    st_nxt.bitcnt = '0;
                    st_nxt = enter(st_nxt, SEG_DEV, 2'd0);
                  end
                end
                SEG_RSTART: begin
                  if (st_r.micro < 2'd3) begin
                    st_nxt = enter(st_nxt, SEG_RSTART, micro_inc);
                  end else begin
                    st_nxt.shift = st_r.dev | 8'h01;
                    st_nxt.bitcnt = '0;
                    st_nxt = enter(st_nxt, SEG_RDEV, 2'd0);
                  end
                end
                SEG_DEV, SEG_OFF, SEG_WDATA, SEG_RDEV: begin
                  if (st_r.micro < 2'd2) begin
                    st_nxt = enter(st_nxt, st_r.seg, micro_inc);
                  end else if (st_r.bitcnt < 4'd8) begin
                    st_nxt.bitcnt = bit_inc;
                    st_nxt = enter(st_nxt, st_r.seg, 2'd0);
                  end else begin
                    st_nxt.bitcnt = '0;
                    case (st_r.seg)
                      SEG_DEV: begin
                        if (sda_in) begin
                          st_nxt.status = ST_NO_ACK;
                          st_nxt = enter(st_nxt, SEG_STOP, 2'd0);
                        end else begin
                          st_nxt.shift = st_r.offs;
                          st_nxt = enter(st_nxt, SEG_OFF, 2'd0);
                        end
                      end
                      SEG_OFF: begin
                        if (st_r.is_read) begin
                          st_nxt = enter(st_nxt, SEG_RSTART, 2'd0);
                        end else if (st_r.left == '0) begin
                          st_nxt = enter(st_nxt, SEG_STOP, 2'd0);
                        end else begin
                          st_nxt = enter(st_nxt, SEG_WAIT, 2'd0);
                        end
                      end
                      SEG_WDATA: begin
                        st_nxt.left = left_dec;
                        if (left_dec == '0) begin
                          st_nxt = enter(st_nxt, SEG_STOP, 2'd0);
                        end else begin
                          st_nxt = enter(st_nxt, SEG_WAIT, 2'd0);
                        end
                      end
                      default: begin
                        if (st_r.left == '0) begin
                          st_nxt = enter(st_nxt, SEG_STOP, 2'd0);
                        end else begin
                          st_nxt.shift = '0;
                          st_nxt = enter(st_nxt, SEG_RECV, 2'd0);
                        end
                      end
                    endcase
                  end
                end
                SEG_RECV: begin
                  if (st_r.micro == 2'd0) begin
                    st_nxt = enter(st_nxt, SEG_RECV, 2'd1);
                  end else if (bit_inc < 4'd8) begin
                    st_nxt.shift = recv_byte;
                    st_nxt.bitcnt = bit_inc;
                    st_nxt = enter(st_nxt, SEG_RECV, 2'd0);
                  end else begin
                    st_nxt.shift = recv_byte;
                    st_nxt.bitcnt = '0;
                    ev_valid = 1'b1;
                    ev_data = recv_byte;
                    ev_last = (st_r.left == 16'd1);
                    st_nxt = enter(st_nxt, SEG_RACK, 2'd0);
                  end
                end
                SEG_RACK: begin
                  if (st_r.micro < 2'd3) begin
                    st_nxt = enter(st_nxt, SEG_RACK, micro_inc);
                  end else begin
                    st_nxt.left = left_dec;
                    if (left_dec == '0) begin
                      st_nxt = enter(st_nxt, SEG_STOP, 2'd0);
                    end else begin
                      st_nxt.shift = '0;
                      st_nxt = enter(st_nxt, SEG_RECV, 2'd0);
                    end
                  end
                end
                SEG_STOP: begin
                  if (st_r.micro < 2'd3) begin
                    st_nxt = enter(st_nxt, SEG_STOP, micro_inc);
                  end else begin
                    ev_done = 1'b1;
                    st_nxt.bitcnt = '0;
                    st_nxt = enter(st_nxt, SEG_IDLE, 2'd0);
                  end
                end
                default: st_nxt = enter(st_nxt, SEG_IDLE, 2'd0);
              endcase
            end
          end
        end
        REQ_BYTE: begin
          if (st_r.seg == SEG_WAIT) begin
            st_nxt.shift = write_data;
            st_nxt.bitcnt = '0;
            st_nxt = enter(st_nxt, SEG_WDATA, 2'd0);
          end
        end
        default: begin
          if (st_r.seg == SEG_IDLE) begin
            st_nxt.dev = {cfg.device_code, mem_address[ADDR_W-1:PAGE_BITS], 1'b0};
            st_nxt.offs = mem_address[PAGE_BITS-1:0];
            st_nxt.left = byte_count;
            st_nxt.is_read = (req_type == REQ_READ);
            st_nxt.status = ST_OK;
            st_nxt.bitcnt = '0;
            st_nxt.shift = '0;
            st_nxt = enter(st_nxt, SEG_START, 2'd0);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.seg <= SEG_IDLE;
      st_r.micro <= '0;
      st_r.timer <= '0;
      st_r.bitcnt <= '0;
      st_r.shift <= '0;
      st_r.left <= '0;
      st_r.is_read <= 1'b0;
      st_r.dev <= '0;
      st_r.offs <= '0;
      st_r.scl <= 1'b1;
      st_r.sda <= 1'b1;
      st_r.status <= ST_OK;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    res.scl_out = st_nxt.scl;
    res.sda_out = st_nxt.sda;
    res.read_data = ev_data;
    res.read_valid = ev_valid;
    res.read_last = ev_last;
    res.want_byte = (st_nxt.seg == SEG_WAIT);
    res.busy_res = (st_nxt.seg != SEG_IDLE);
    res.done_res = ev_done;
    res.status = st_nxt.status;
  end

endmodule
`default_nettype wire

/* hw/rtl/i2cmm_outq.sv */
`default_nettype none
module i2cmm_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire i2cmm_pkg::res_t  push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop_stall,
  output i2cmm_pkg::res_t       pop_data
);
  import i2cmm_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign full = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop = pop_valid && !pop_stall;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/i2c_memory_master.sv */
`default_nettype none
// Pin-level I2C master for a serial memory doing random reads and sequential
// writes. Every request (a tick, a begin, or a write byte) produces exactly one
// result, and one request can be taken in every clock cycle: the sequencer
// advances by at most one bus phase per request, and results sit in a
// two-entry queue so that a stalled result side does not stop the next request
// until that queue is full. Bus timing is counted in tick requests, not in
// clock cycles, so ticks_per_phase sets the SCL rate relative to the tick
// stream. Configuration writes are always ready and should be made only
// while no transaction is running.
module i2c_memory_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [10:0] in_mem_address,
  input  wire logic [15:0] in_byte_count,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic [7:0]       out_read_data,
  output logic             out_read_valid,
  output logic             out_read_last,
  output logic             out_want_byte,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import i2cmm_pkg::*;

  cfg_t cfg_r;
  res_t step_res;
  res_t q_res;
  logic accept;
  logic q_full;

  assign cfg_ready = 1'b1;
  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_code <= DEVICE_CODE_RST;
      cfg_r.ticks_per_phase <= TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_CODE: cfg_r.device_code <= cfg_data[3:0];
        CFG_TICKS: cfg_r.ticks_per_phase <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  i2cmm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .mem_address (in_mem_address),
    .byte_count  (in_byte_count),
    .write_data  (in_write_data),
    .sda_in      (in_sda_in),
    .cfg         (cfg_r),
    .res         (step_res)
  );

  i2cmm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .full      (q_full),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (q_res)
  );

  assign out_scl_out = q_res.scl_out;
  assign out_sda_out = q_res.sda_out;
  assign out_read_data = q_res.read_data;
  assign out_read_valid = q_res.read_valid;
  assign out_read_last = q_res.read_last;
  assign out_want_byte = q_res.want_byte;
  assign out_busy_res = q_res.busy_res;
  assign out_done_res = q_res.done_res;
  assign out_status = q_res.status;

endmodule
`default_nettype wire

/* hw/rtl/i2cmm_checker.sv */
`default_nettype none
module i2cmm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_scl_out,
  input  wire logic        out_sda_out,
  input  wire logic [7:0]  out_read_data,
  input  wire logic        out_read_valid,
  input  wire logic        out_read_last,
  input  wire logic        out_want_byte,
  input  wire logic        out_busy_res,
  input  wire logic        out_done_res,
  input  wire logic [1:0]  out_status
);

  // A finished transaction leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // Only a running write can ask for a byte, and it then holds SCL low.
  a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_want_byte |-> out_busy_res && !out_scl_out)
    else $error("byte request outside a write or with SCL released");

  // The last-byte flag and the data belong to a received byte only.
  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> !out_read_last && out_read_data == 8'd0)
    else $error("read flags or data without a received byte");

  // Idle results show both lines released.
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_out && out_sda_out)
    else $error("bus lines driven while idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_status) && $stable(out_scl_out) && $stable(out_sda_out))
    else $error("stalled request changed");

endmodule

bind i2c_memory_master i2cmm_checker u_i2cmm_checker (.*);
`default_nettype wire

/* verif/i2c_memory_master_tb.sv */
module i2c_memory_master_tb;
  import i2cmm_pkg::*;

  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_DEV, SEQ_OFF, SEQ_WAIT, SEQ_WDATA,
    SEQ_RSTART, SEQ_RDEV, SEQ_RECV, SEQ_RACK, SEQ_STOP
  } bus_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_TICK;
  logic [10:0] in_mem_address = '0;
  logic [15:0] in_byte_count = '0;
  logic [7:0] in_write_data = '0;
  logic in_sda_in = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_scl_out;
  logic out_sda_out;
  logic [7:0] out_read_data;
  logic out_read_valid;
  logic out_read_last;
  logic out_want_byte;
  logic out_busy_res;
  logic out_done_res;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_DEVICE_CODE;
  logic [10:0] cfg_data = '0;

  // Shadow of the bus sequencer, advanced once per accepted request.
  bus_step_t bus_step = SEQ_IDLE;
  logic [1:0] bus_micro = '0;
  int unsigned phase_ticks = 0;
  logic [3:0] bit_index = '0;
  logic [7:0] shift_reg = '0;
  logic [15:0] bytes_remaining = '0;
  logic reading = 1'b0;
  logic [7:0] dev_byte = '0;
  logic [7:0] word_off = '0;
  logic scl_drv = 1'b1;
  logic sda_drv = 1'b1;
  logic [1:0] txn_status = ST_OK;
  logic [3:0] code_cfg = DEVICE_CODE_RST;
  logic [10:0] ticks_cfg = TICKS_RST;
  logic byte_ready, byte_final, txn_done;
  logic [7:0] byte_value;

  res_t pending_bus_results[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_off = 1'b0;
  logic refuse_ack = 1'b0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_read = 0;
  int unsigned txns_done = 0;
  int unsigned cycle_count = 0;

  i2c_memory_master i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_mem_address(in_mem_address), .in_byte_count(in_byte_count),
    .in_write_data(in_write_data), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_scl_out(out_scl_out),
    .out_sda_out(out_sda_out), .out_read_data(out_read_data),
    .out_read_valid(out_read_valid), .out_read_last(out_read_last),
    .out_want_byte(out_want_byte), .out_busy_res(out_busy_res),
    .out_done_res(out_done_res), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("i2c_memory_master_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic enter_bus_step(bus_step_t nxt, logic [1:0] m);
    bus_step = nxt;
    bus_micro = m;
    phase_ticks = 0;
    case (nxt)
      SEQ_START: begin
        if (m == 2'd0) begin
          scl_drv = 1'b1;
          sda_drv = 1'b1;
        end else if (m == 2'd1) begin
          sda_drv = 1'b0;
        end
      end
      SEQ_RSTART: begin
        if (m == 2'd0) begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
        end else if (m == 2'd1) begin
          scl_drv = 1'b1;
        end else if (m == 2'd2) begin
          sda_drv = 1'b0;
        end
      end
      SEQ_DEV, SEQ_OFF, SEQ_WDATA, SEQ_RDEV: begin
        if (m == 2'd0) begin
          scl_drv = 1'b0;
        end else if (m == 2'd1) begin
          if (bit_index < 4'd8) begin
            sda_drv = shift_reg[7];
            shift_reg = {shift_reg[6:0], 1'b0};
          end else begin
            sda_drv = 1'b1;
          end
        end else begin
          scl_drv = 1'b1;
        end
      end
      SEQ_WAIT: scl_drv = 1'b0;
      SEQ_RECV: begin
        if (m == 2'd0) begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
        end else begin
          scl_drv = 1'b1;
        end
      end
      SEQ_RACK: begin
        if (m == 2'd0 || m == 2'd3) begin
          scl_drv = 1'b0;
        end else if (m == 2'd1) begin
          sda_drv = (bytes_remaining == 16'd1);
        end else begin
          scl_drv = 1'b1;
        end
      end
      SEQ_STOP: begin
        if (m == 2'd0) begin
          scl_drv = 1'b0;
        end else if (m == 2'd1) begin
          sda_drv = 1'b0;
        end else if (m == 2'd2) begin
          scl_drv = 1'b1;
        end else begin
          sda_drv = 1'b1;
        end
      end
      default: begin
        bus_step = SEQ_IDLE;
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
    endcase
  endtask

  task automatic close_transaction(logic [1:0] st);
    txn_status = st;
    txn_done = 1'b1;
    bit_index = '0;
    enter_bus_step(SEQ_IDLE, 2'd0);
  endtask

  task automatic enter_after_data();
    if (bytes_remaining == 16'd0) enter_bus_step(SEQ_STOP, 2'd0);
    else enter_bus_step(SEQ_WAIT, 2'd0);
  endtask

  task automatic step_bus_model(logic [1:0] req, logic [10:0] addr, logic [15:0] count,
                                logic [7:0] wdata, logic line_sda, output res_t r);
    int unsigned period;
    period = (ticks_cfg == 11'd0) ? 1 : ((ticks_cfg > MAX_PERIOD) ? 1024 : ticks_cfg);
    byte_ready = 1'b0;
    byte_value = '0;
    byte_final = 1'b0;
    txn_done = 1'b0;
    if (req == REQ_TICK) begin
      if (bus_step != SEQ_IDLE && bus_step != SEQ_WAIT) begin
        phase_ticks++;
        if (phase_ticks >= period) begin
          phase_ticks = 0;
          case (bus_step)
            SEQ_START: begin
              if (bus_micro == 2'd0) begin
                if (!line_sda) close_transaction(ST_BUS_BUSY);
                else enter_bus_step(SEQ_START, 2'd1);
              end else if (bus_micro == 2'd1) begin
                if (line_sda) close_transaction(ST_BUS_ERR);
                else enter_bus_step(SEQ_START, 2'd2);
              end else begin
                shift_reg = dev_byte;
                bit_index = '0;
                enter_bus_step(SEQ_DEV, 2'd0);
              end
            end
            SEQ_RSTART: begin
              if (bus_micro < 2'd3) begin
                enter_bus_step(SEQ_RSTART, bus_micro + 2'd1);
              end else begin
                shift_reg = dev_byte | 8'h01;
                bit_index = '0;
                enter_bus_step(SEQ_RDEV, 2'd0);
              end
            end
            SEQ_DEV, SEQ_OFF, SEQ_WDATA, SEQ_RDEV: begin
              if (bus_micro < 2'd2) begin
                enter_bus_step(bus_step, bus_micro + 2'd1);
              end else if (bit_index < 4'd8) begin
                bit_index++;
                enter_bus_step(bus_step, 2'd0);
              end else begin
                bit_index = '0;
                case (bus_step)
                  SEQ_DEV: begin
                    if (line_sda) begin
                      txn_status = ST_NO_ACK;
                      enter_bus_step(SEQ_STOP, 2'd0);
                    end else begin
                      shift_reg = word_off;
                      enter_bus_step(SEQ_OFF, 2'd0);
                    end
                  end
                  SEQ_OFF: begin
                    if (reading) enter_bus_step(SEQ_RSTART, 2'd0);
                    else enter_after_data();
                  end
                  SEQ_WDATA: begin
                    bytes_remaining--;
                    enter_after_data();
                  end
                  default: begin
                    if (bytes_remaining == 16'd0) begin
                      enter_bus_step(SEQ_STOP, 2'd0);
                    end else begin
                      shift_reg = '0;
                      enter_bus_step(SEQ_RECV, 2'd0);
                    end
                  end
                endcase
              end
            end
            SEQ_RECV: begin
              if (bus_micro == 2'd0) begin
                enter_bus_step(SEQ_RECV, 2'd1);
              end else begin
                shift_reg = {shift_reg[6:0], line_sda};
                bit_index++;
                if (bit_index < 4'd8) begin
                  enter_bus_step(SEQ_RECV, 2'd0);
                end else begin
                  bit_index = '0;
                  byte_ready = 1'b1;
                  byte_value = shift_reg;
                  byte_final = (bytes_remaining == 16'd1);
                  enter_bus_step(SEQ_RACK, 2'd0);
                end
              end
            end
            SEQ_RACK: begin
              if (bus_micro < 2'd3) begin
                enter_bus_step(SEQ_RACK, bus_micro + 2'd1);
              end else begin
                bytes_remaining--;
                if (bytes_remaining == 16'd0) begin
                  enter_bus_step(SEQ_STOP, 2'd0);
                end else begin
                  shift_reg = '0;
                  enter_bus_step(SEQ_RECV, 2'd0);
                end
              end
            end
            SEQ_STOP: begin
              if (bus_micro < 2'd3) enter_bus_step(SEQ_STOP, bus_micro + 2'd1);
              else close_transaction(txn_status);
            end
            default: enter_bus_step(SEQ_IDLE, 2'd0);
          endcase
        end
      end
    end else if (req == REQ_BYTE) begin
      if (bus_step == SEQ_WAIT) begin
        shift_reg = wdata;
        bit_index = '0;
        enter_bus_step(SEQ_WDATA, 2'd0);
      end
    end else if (bus_step == SEQ_IDLE) begin
      dev_byte = {code_cfg, addr[10:8], 1'b0};
      word_off = addr[7:0];
      bytes_remaining = count;
      reading = (req == REQ_READ);
      txn_status = ST_OK;
      bit_index = '0;
      shift_reg = '0;
      enter_bus_step(SEQ_START, 2'd0);
    end
    r.scl_out = scl_drv;
    r.sda_out = sda_drv;
    r.read_data = byte_value;
    r.read_valid = byte_ready;
    r.read_last = byte_final;
    r.want_byte = (bus_step == SEQ_WAIT);
    r.busy_res = (bus_step != SEQ_IDLE);
    r.done_res = txn_done;
    r.status = txn_status;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) begin
      $display("i2c_memory_master_tb: mismatch on %s in result %0d: got %0h, expected %0h",
               what, results_checked, got, want);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_out, out_sda_out, out_read_data, out_read_valid, out_read_last,
             out_want_byte, out_busy_res, out_done_res, out_status};
      if (pending_bus_results.size() == 0) begin
        check_field("result with no request pending", 1, 0);
      end else begin
        want = pending_bus_results.pop_front();
        check_field("scl_out", got.scl_out, want.scl_out);
        check_field("sda_out", got.sda_out, want.sda_out);
        check_field("read_data", got.read_data, want.read_data);
        check_field("read_valid", got.read_valid, want.read_valid);
        check_field("read_last", got.read_last, want.read_last);
        check_field("want_byte", got.want_byte, want.want_byte);
        check_field("busy_res", got.busy_res, want.busy_res);
        check_field("done_res", got.done_res, want.done_res);
        check_field("status", got.status, want.status);
        if (want.read_valid) bytes_read++;
      end
      results_checked++;
    end
  end

  task automatic send_request(logic [1:0] req, logic [10:0] addr, logic [15:0] count,
                              logic [7:0] wdata, logic line_sda);
    res_t expected;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_mem_address <= addr;
    in_byte_count <= count;
    in_write_data <= wdata;
    in_sda_in <= line_sda;
    do @(posedge clk); while (in_stall);
    step_bus_model(req, addr, count, wdata, line_sda, expected);
    pending_bus_results.push_back(expected);
    requests_sent++;
  endtask

  task automatic send_tick(logic line_sda);
    send_request(REQ_TICK, 11'($urandom), 16'($urandom), 8'($urandom), line_sda);
  endtask

  // The SDA level a well-behaved memory would present on the next tick.
  function automatic logic memory_sda();
    if (bus_step == SEQ_START && bus_micro == 2'd0) return 1'b1;
    if (bus_step == SEQ_START && bus_micro == 2'd1) return 1'b0;
    if (bus_step == SEQ_DEV && bit_index == 4'd8 && bus_micro == 2'd2) return refuse_ack;
    return 1'($urandom);
  endfunction

  task automatic run_txn(logic [1:0] kind, logic [10:0] addr, logic [15:0] count,
                         int unsigned noise_pct, int unsigned stray_pct);
    logic [7:0] data;
    send_request(kind, addr, count, 8'($urandom), 1'($urandom));
    while (bus_step != SEQ_IDLE) begin
      if ($urandom_range(99) < stray_pct) begin
        send_request(2'($urandom), 11'($urandom), 16'($urandom), 8'($urandom),
                     1'($urandom));
      end else if (bus_step == SEQ_WAIT) begin
        case ($urandom_range(3))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        send_request(REQ_BYTE, 11'($urandom), 16'($urandom), data, 1'($urandom));
      end else if ($urandom_range(99) < noise_pct) begin
        send_tick(1'($urandom));
      end else begin
        send_tick(memory_sda());
      end
    end
    txns_done++;
  endtask

  task automatic run_fixed_sda(logic [1:0] kind, logic [10:0] addr, logic [15:0] count,
                               logic level);
    send_request(kind, addr, count, 8'($urandom), 1'($urandom));
    while (bus_step != SEQ_IDLE) send_tick(level);
    txns_done++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_bus_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_bus_config(logic [3:0] code, logic [10:0] ticks, bit poke_spare);
    logic [1:0] idx[$];
    logic [10:0] val[$];
    idx = '{CFG_DEVICE_CODE, CFG_TICKS};
    val = '{{7'($urandom), code}, ticks};
    if (poke_spare) begin
      idx.push_back(CFG_SPARE_2);
      val.push_back(11'($urandom));
      idx.push_back(CFG_SPARE_3);
      val.push_back(11'($urandom));
    end
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      if (idx[i] == CFG_DEVICE_CODE) code_cfg = val[i][3:0];
      else if (idx[i] == CFG_TICKS) ticks_cfg = val[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_requests();
    send_tick(1'b0);
    send_tick(1'b1);
    send_request(REQ_BYTE, 11'h7FF, 16'hFFFF, 8'hFF, 1'b0);
  endtask

  task automatic test_start_failures();
    run_fixed_sda(REQ_WRITE, 11'h000, 16'h0000, 1'b0);
    run_fixed_sda(REQ_READ, 11'h7FF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_missing_ack();
    refuse_ack = 1'b1;
    run_txn(REQ_WRITE, 11'h7FF, 16'hFFFF, 0, 0);
    run_txn(REQ_READ, 11'h2AA, 16'd2, 0, 0);
    refuse_ack = 1'b0;
  endtask

  task automatic test_write_and_read();
    run_txn(REQ_WRITE, 11'h7FF, 16'd2, 0, 8);
    run_txn(REQ_READ, 11'h000, 16'd3, 0, 8);
    run_txn(REQ_WRITE, 11'h100, 16'd0, 0, 0);
    run_txn(REQ_READ, 11'h4FF, 16'd0, 0, 0);
    run_txn(REQ_READ, 11'h6C3, 16'd1, 0, 0);
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    set_bus_config(4'h0, 11'd0, 1'b1);
    run_txn(REQ_WRITE, 11'h3A5, 16'd1, 0, 0);
    wait_results_drained();
    set_bus_config(4'hF, 11'd1, 1'b1);
    run_txn(REQ_READ, 11'h7FF, 16'd0, 0, 0);
  endtask

  task automatic test_result_backpressure();
    // Results are held back long enough for the request side to back up.
    fork
      begin
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_txn(REQ_READ, 11'h155, 16'd3, 0, 0);
  endtask

  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                     int unsigned quota);
    int unsigned stop_at;
    logic [15:0] count;
    bit noisy;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      wait_results_drained();
      set_bus_config(4'($urandom), 11'($urandom_range(3, 1)), $urandom_range(3) == 0);
      noisy = ($urandom_range(4) == 0);
      refuse_ack = ($urandom_range(9) == 0);
      count = ($urandom_range(7) == 0) ? 16'($urandom_range(12)) : 16'($urandom_range(3));
      repeat ($urandom_range(2)) send_tick(1'($urandom));
      run_txn($urandom_range(1) ? REQ_READ : REQ_WRITE, 11'($urandom), count,
              noisy ? 30 : 0, noisy ? 10 : 2);
    end
    refuse_ack = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 10;
    recv_stall_pct = 66;
    test_idle_requests();
    test_start_failures();
    test_missing_ack();
    test_write_and_read();
    test_register_extremes();
    test_result_backpressure();
    test_random_traffic(10, 66, 100);
    test_random_traffic(66, 10, 100);
    test_random_traffic(0, 0, 100);
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("i2c_memory_master_tb: %0d requests in %0d transactions, %0d results, %0d bytes read",
             requests_sent, txns_done, results_checked, bytes_read);
    $display("i2c_memory_master_tb: start failures, missing acks, tick periods 0 to 3, hold-off");
    if (mismatches == 0) begin
      $display("i2c_memory_master_tb: PASS");
    end else begin
      $display("i2c_memory_master_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/i2cmm_pkg.sv
hw/rtl/i2cmm_seq.sv
hw/rtl/i2cmm_outq.sv
hw/rtl/i2c_memory_master.sv
hw/rtl/i2cmm_checker.sv
verif/i2c_memory_master_tb.sv
